>>> design/max_priority_queue_macros.svh
// Assertion macros shared by the priority queue RTL.
`ifndef MAX_PRIORITY_QUEUE_MACROS_SVH
`define MAX_PRIORITY_QUEUE_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define MPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies a condition in the next.
`define MPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/mpq_pkg.sv
// Shared codes and types for the sorted-chain priority queue.
`default_nettype none

package mpq_pkg;

  // Request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> design/mpq_in_if.sv
// Request channel: valid/ready handshake carrying one queue request.
`default_nettype none

interface mpq_in_if #(
  parameter int VW = 32
) ();
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic signed [VW-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

`default_nettype wire

>>> design/mpq_out_if.sv
// Result channel: valid/ready handshake carrying one queue result.
`default_nettype none

interface mpq_out_if #(
  parameter int VW = 32,
  parameter int CW = 7
) ();
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] out_value;
  logic [1:0]           status;
  logic [CW-1:0]        count;

  modport source (output valid, output out_value, output status, output count, input ready);
  modport sink   (input valid, input out_value, input status, input count, output ready);
endinterface

`default_nettype wire

>>> design/mpq_cell.sv
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
`default_nettype none

module mpq_cell #(
  parameter int VW = 32
) (
  input  wire logic                 clk,
  input  wire mpq_pkg::cell_cmd_t   cmd,
  input  wire logic                 occupied,
  input  wire logic signed [VW-1:0] new_value,
  input  wire logic                 left_after,
  input  wire logic signed [VW-1:0] left_value,
  input  wire logic signed [VW-1:0] right_value,
  output logic signed [VW-1:0]      value,
  output logic                      after
);

  logic signed [VW-1:0] value_r;
  logic signed [VW-1:0] value_nxt;

  // New item lands at or before this slot: slot is free or holds a smaller value
  assign after = !occupied || (new_value > value_r);
  assign value = value_r;

  // Shift right past the insert point, load at the insert point, shift left on remove
  always_comb begin
    value_nxt = value_r;
    if (cmd.ins) begin
      if (left_after) begin
        value_nxt = left_value;
      end else if (after) begin
        value_nxt = new_value;
      end
    end else if (cmd.rem) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

`default_nettype wire

>>> design/max_priority_queue.sv
// Top level of the bounded max-priority queue built as a sorted register chain.
// A result is registered and presented in the cycle after its request is accepted.
// Throughput: one request per cycle unless a result is held back by out_ch.ready;
// every cell compares against the new value in parallel to find the insert point.
// Reset (rst_n low, synchronous) empties the queue and clears the result valid.
`default_nettype none
`include "max_priority_queue_macros.svh"

module max_priority_queue #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  mpq_in_if.sink   in_ch,
  mpq_out_if.source out_ch
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]                 count_r;
  logic [CW-1:0]                 count_nxt;
  logic                          out_valid_r;
  logic signed [VALUE_WIDTH-1:0] out_value_r;
  logic signed [VALUE_WIDTH-1:0] out_value_nxt;
  logic [1:0]                    status_r;
  logic [1:0]                    status_nxt;
  logic [CW-1:0]                 out_count_r;

  logic                          fire;
  logic                          full;
  logic                          empty;
  logic                          ins_ok;
  logic                          rem_ok;
  mpq_pkg::cell_cmd_t            cmd;

  logic signed [VALUE_WIDTH-1:0] cell_val   [CAPACITY];
  logic                          cell_after [CAPACITY];

  // Accept whenever the output register is free or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;

  assign full   = (count_r == CW'(CAPACITY));
  assign empty  = (count_r == '0);
  assign ins_ok = fire && (in_ch.req_type == mpq_pkg::REQ_INSERT) && !full;
  assign rem_ok = fire && (in_ch.req_type == mpq_pkg::REQ_REMOVE) && !empty;

  assign cmd.ins = ins_ok;
  assign cmd.rem = rem_ok;

  // Build the chain of cells
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                          occ;
      logic                          l_after;
      logic signed [VALUE_WIDTH-1:0] l_val;
      logic signed [VALUE_WIDTH-1:0] r_val;

      assign occ = (CW'(gi) < count_r);

      if (gi == 0) begin : g_head
        assign l_after = 1'b0;
        assign l_val   = in_ch.value;
      end else begin : g_body
        assign l_after = cell_after[gi-1];
        assign l_val   = cell_val[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_tail
        assign r_val = cell_val[gi];
      end else begin : g_inner
        assign r_val = cell_val[gi+1];
      end

      mpq_cell #(
        .VW (VALUE_WIDTH)
      ) u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .occupied    (occ),
        .new_value   (in_ch.value),
        .left_after  (l_after),
        .left_value  (l_val),
        .right_value (r_val),
        .value       (cell_val[gi]),
        .after       (cell_after[gi])
      );
    end
  endgenerate

  // Update the entry count
  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (rem_ok) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // Form the result of the accepted item
  always_comb begin
    out_value_nxt = '0;
    status_nxt    = mpq_pkg::STATUS_OK;
    if (in_ch.req_type == mpq_pkg::REQ_REMOVE) begin
      if (empty) begin
        status_nxt = mpq_pkg::STATUS_EMPTY;
      end else begin
        out_value_nxt = cell_val[0];
      end
    end else if (full) begin
      status_nxt = mpq_pkg::STATUS_FULL;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_value_r <= out_value_nxt;
      status_r    <= status_nxt;
      out_count_r <= count_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.status    = status_r;
  assign out_ch.count     = out_count_r;

  // Checks
  `MPQ_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(CAPACITY), "entry count above capacity")
  `MPQ_ASSERT_NEXT(a_remove_count, rem_ok, count_r == $past(count_r) - CW'(1), "remove did not drop count")
  `MPQ_ASSERT_ALWAYS(a_full_count, !out_valid_r || status_r != mpq_pkg::STATUS_FULL || out_count_r == CW'(CAPACITY), "full status with count below capacity")
  `MPQ_ASSERT_ALWAYS(a_fail_zero, !out_valid_r || status_r == mpq_pkg::STATUS_OK || out_value_r == '0, "failed request returned a value")

endmodule

`default_nettype wire

>>> bench/max_priority_queue_test.sv
// Self-checking testbench for the sorted-chain max-priority queue.
`default_nettype none

module max_priority_queue_test;

  localparam int QUEUE_DEPTH = 64;
  localparam int VW          = 32;
  localparam int CW          = 7;

  // One result as seen on the output channel
  typedef struct packed {
    logic signed [VW-1:0] value;
    logic [1:0]           status;
    logic [CW-1:0]        count;
  } qresult_t;

  // Directed row: request, first value, repeat count, value step, and an
  // optional result typed in by hand
  typedef struct packed {
    logic                 req;
    logic signed [VW-1:0] val;
    int                   reps;
    int                   stride;
    bit                   chk;
    logic signed [VW-1:0] e_val;
    logic [1:0]           e_status;
    logic [CW-1:0]        e_count;
  } step_t;

  // Hand-typed result waiting for its request to be accepted
  typedef struct packed {
    bit       chk;
    qresult_t r;
  } listed_t;

  logic clk;
  logic rst_n;

  mpq_in_if  #(.VW(VW))          in_ch ();
  mpq_out_if #(.VW(VW), .CW(CW)) out_ch ();

  max_priority_queue #(
    .CAPACITY    (QUEUE_DEPTH),
    .VALUE_WIDTH (VW)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic signed [VW-1:0] sorted_vals[$];
  qresult_t             due_results[$];
  listed_t              listed_results[$];
  int                   mismatch_count = 0;
  bit                   idle_on        = 1'b1;
  bit                   hold_off_req   = 1'b0;

  step_t plan [23] = '{
    '{mpq_pkg::REQ_REMOVE, 0,            1,  0, 1, 0,            mpq_pkg::STATUS_EMPTY, 0},
    '{mpq_pkg::REQ_INSERT, 32'h7fffffff, 1,  0, 1, 0,            mpq_pkg::STATUS_OK,    1},
    '{mpq_pkg::REQ_INSERT, 32'h80000000, 1,  0, 1, 0,            mpq_pkg::STATUS_OK,    2},
    '{mpq_pkg::REQ_INSERT, 0,            1,  0, 0, 0,            mpq_pkg::STATUS_OK,    0},
    '{mpq_pkg::REQ_INSERT, -1,           1,  0, 0, 0,            mpq_pkg::STATUS_OK,    0},
    '{mpq_pkg::REQ_INSERT, 0,            1,  0, 0, 0,            mpq_pkg::STATUS_OK,    0},
    '{mpq_pkg::REQ_INSERT, 1,            1,  0, 0, 0,            mpq_pkg::STATUS_OK,    0},
    '{mpq_pkg::REQ_REMOVE, 0,            1,  0, 1, 32'h7fffffff, mpq_pkg::STATUS_OK,    5},
    '{mpq_pkg::REQ_REMOVE, 0,            1,  0, 0, 0,            mpq_pkg::STATUS_OK,    0},
    '{mpq_pkg::REQ_REMOVE, 0,            1,  0, 0, 0,            mpq_pkg::STATUS_OK,    0},
    '{mpq_pkg::REQ_REMOVE, 0,            1,  0, 0, 0,            mpq_pkg::STATUS_OK,    0},
    '{mpq_pkg::REQ_REMOVE, 0,            1,  0, 0, 0,            mpq_pkg::STATUS_OK,    0},
    '{mpq_pkg::REQ_REMOVE, 0,            1,  0, 1, 32'h80000000, mpq_pkg::STATUS_OK,    0},
    '{mpq_pkg::REQ_REMOVE, 0,            1,  0, 1, 0,            mpq_pkg::STATUS_EMPTY, 0},
    '{mpq_pkg::REQ_INSERT, 32'h55555555, 1,  0, 0, 0,            mpq_pkg::STATUS_OK,    0},
    '{mpq_pkg::REQ_INSERT, 32'haaaaaaaa, 1,  0, 0, 0,            mpq_pkg::STATUS_OK,    0},
    '{mpq_pkg::REQ_REMOVE, 0,            1,  0, 0, 0,            mpq_pkg::STATUS_OK,    0},
    '{mpq_pkg::REQ_REMOVE, 0,            1,  0, 0, 0,            mpq_pkg::STATUS_OK,    0},
    '{mpq_pkg::REQ_INSERT, -32,          64, 1, 0, 0,            mpq_pkg::STATUS_OK,    0},
    '{mpq_pkg::REQ_INSERT, 12345,        1,  0, 1, 0,            mpq_pkg::STATUS_FULL,  64},
    '{mpq_pkg::REQ_REMOVE, 0,            1,  0, 1, 31,           mpq_pkg::STATUS_OK,    63},
    '{mpq_pkg::REQ_INSERT, 32'h7fffffff, 1,  0, 0, 0,            mpq_pkg::STATUS_OK,    0},
    '{mpq_pkg::REQ_INSERT, 32'h80000000, 1,  0, 1, 0,            mpq_pkg::STATUS_FULL,  64}
  };

  // Share of inserts in percent for each random block
  int ins_pct [13] = '{30, 90, 10, 85, 95, 15, 50, 70, 5, 90, 40, 60, 50};

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Reset, held low from time zero and then released
  initial begin
    rst_n = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
  end

  // Run limit
  initial begin
    #2000000;
    $display("max_priority_queue_test: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 200)
      $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Apply one request to the sorted copy and return the result it yields
  function automatic qresult_t queue_step(input logic req, input logic signed [VW-1:0] val);
    qresult_t r;
    int       pos;
    r = '0;
    r.status = mpq_pkg::STATUS_OK;
    if (req == mpq_pkg::REQ_INSERT) begin
      if (sorted_vals.size() >= QUEUE_DEPTH) begin
        r.status = mpq_pkg::STATUS_FULL;
      end else begin
        // new value goes after every equal entry
        pos = sorted_vals.size();
        for (int i = 0; i < sorted_vals.size(); i++) begin
          if (val > sorted_vals[i]) begin
            pos = i;
            break;
          end
        end
        sorted_vals.insert(pos, val);
      end
    end else if (sorted_vals.size() == 0) begin
      r.status = mpq_pkg::STATUS_EMPTY;
    end else begin
      r.value = sorted_vals.pop_front();
    end
    r.count = CW'(sorted_vals.size());
    return r;
  endfunction

  // Predict on each accepted request, check each accepted result
  always @(posedge clk) begin : track
    qresult_t want;
    qresult_t got;
    listed_t  row;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        want = queue_step(in_ch.req_type, in_ch.value);
        if (listed_results.size() > 0) begin
          row = listed_results.pop_front();
          if (row.chk) want = row.r;
        end
        due_results.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.value  = out_ch.out_value;
        got.status = out_ch.status;
        got.count  = out_ch.count;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result with none expected: value %0d status %0d count %0d",
                                    got.value, got.status, got.count));
        end else begin
          want = due_results.pop_front();
          if (got.value !== want.value)
            report_mismatch($sformatf("out_value %0d, expected %0d", got.value, want.value));
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
          if (got.count !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d", got.count, want.count));
        end
      end
    end
  end

  // Result side: random stall bursts, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (160) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  // Offer one request at a falling edge and hold it until accepted
  task automatic send_item(input logic req, input logic signed [VW-1:0] val);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.value    <= val;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Drop the offer, then wait until every expected result has come back, with a guard
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    do begin
      @(negedge clk);
      guard++;
    end while (due_results.size() != 0 && guard < 20000);
  endtask

  // Mix of full-range, duplicate-heavy and extreme values
  function automatic logic signed [VW-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom;
    if (sel < 8) return $signed($urandom_range(0, 15)) - 8;
    case ($urandom_range(0, 4))
      0:       return 32'h7fffffff;
      1:       return 32'h80000000;
      2:       return 0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  // Stimulus
  initial begin
    listed_t row;
    logic    req;
    in_ch.valid    = 1'b0;
    in_ch.req_type = mpq_pkg::REQ_INSERT;
    in_ch.value    = '0;
    while (!rst_n) @(negedge clk);
    @(negedge clk);

    // directed rows
    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        row.chk      = plan[i].chk && plan[i].reps == 1;
        row.r.value  = plan[i].e_val;
        row.r.status = plan[i].e_status;
        row.r.count  = plan[i].e_count;
        listed_results.push_back(row);
        send_item(plan[i].req, plan[i].val + k * plan[i].stride);
      end
    end

    // random blocks with shifting insert share
    for (int b = 0; b < 13; b++) begin
      if (b == 4) hold_off_req = 1'b1;
      if (b == 7) wait_drained();
      if (b == 11) idle_on = 1'b0;
      for (int n = 0; n < 150; n++) begin
        req = ($urandom_range(1, 100) <= ins_pct[b]) ? mpq_pkg::REQ_INSERT
                                                     : mpq_pkg::REQ_REMOVE;
        send_item(req, pick_value());
      end
    end

    // drain and finish
    wait_drained();
    repeat (4) @(posedge clk);
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d results never returned", due_results.size()));
    if (mismatch_count == 0) begin
      $display("max_priority_queue_test: done, clean");
    end else begin
      $display("max_priority_queue_test: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
